>>> design/rwt_pkg.sv
// Shared types, widths and codes of the range watchpoint table.
package rwt_pkg;

   localparam int PROC_W     = 22;
   localparam int ADDR_W     = 64;
   localparam int LEN_W      = 64;
   localparam int ACC_W      = 3;
   localparam int HITS_W     = 32;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 3;
   localparam int TOTAL_W    = 7;
   localparam int MAX_RESULTS = 16;
   localparam int EMIT_W     = $clog2(MAX_RESULTS + 1);
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 200;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      REQ_ADD    = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_CLEAR  = 3'd2,
      REQ_FAULT  = 3'd3,
      REQ_LIST   = 3'd4
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD       = 3'd4
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_EXEC  = 2'd2,
      KIND_BAD   = 2'd3
   } fault_kind_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PROBE,
      CELL_ADD,
      CELL_REMOVE,
      CELL_CLEAR,
      CELL_BUMP,
      CELL_ROTATE
   } cell_cmd_type;

   // Input item payload, lowest field in the lowest bits.
   typedef struct packed {
      logic [4:0]        pad;
      fault_kind_type    kind;
      logic [ACC_W-1:0]  mask;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      logic [PROC_W-1:0] proc;
   } req_data_type;

   // Result item payload, lowest field in the lowest bits.
   typedef struct packed {
      logic [3:0]         pad;
      logic [TOTAL_W-1:0] total;
      logic [HITS_W-1:0]  hits;
      logic [ACC_W-1:0]   access;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  addr;
      logic [PROC_W-1:0]  proc;
      logic               hit;
      status_type         status;
   } rsp_data_type;

   typedef struct packed {
      logic [PROC_W-1:0] proc;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
      logic [ACC_W-1:0]  access;
      logic [HITS_W-1:0] hits;
   } slot_type;

   typedef struct packed {
      logic     valid;
      slot_type slot;
   } entry_type;

   // Command broadcast to every cell, with the probe key taken at accept.
   typedef struct packed {
      cell_cmd_type      cmd;
      logic [PROC_W-1:0] pid;
      logic [ADDR_W-1:0] addr;
   } cell_ctrl_type;

   function automatic logic [ACC_W-1:0] kind_mask(input fault_kind_type kind);
      logic [ACC_W-1:0] mask;
      unique case (kind)
         KIND_READ:  mask = 3'b001;
         KIND_WRITE: mask = 3'b010;
         KIND_EXEC:  mask = 3'b100;
         default:    mask = 3'b000;
      endcase
      return mask;
   endfunction

endpackage

>>> design/rwt_cell.sv
// One watch entry of the table chain, with its local range compare.
module rwt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rwt_pkg::cell_ctrl_type ctrl,
   input  rwt_pkg::entry_type    prev_entry,
   input  rwt_pkg::entry_type    next_entry,
   input  logic                  found_in,
   output logic                  found_out,
   output logic                  sel,
   output rwt_pkg::entry_type    entry
);
   import rwt_pkg::*;

   logic              valid_ff, valid_in;
   slot_type          slot_ff, slot_in;
   logic              cover_ff, cover_in;
   logic [ADDR_W-1:0] offset;
   logic              cover_now;

   // Covered when start <= addr and addr - start < len, which never wraps.
   assign offset    = ctrl.addr - slot_ff.start;
   assign cover_now = valid_ff && (slot_ff.proc == ctrl.pid) &&
                      (ctrl.addr >= slot_ff.start) && (offset < slot_ff.len);

   // The first covering cell from the newest end is the selected one.
   assign sel       = cover_ff & ~found_in;
   assign found_out = found_in | cover_ff;
   assign entry     = '{valid: valid_ff, slot: slot_ff};

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      cover_in = cover_ff;
      unique case (ctrl.cmd)
         CELL_HOLD: ;
         CELL_PROBE: cover_in = cover_now;
         CELL_ADD: begin
            valid_in = prev_entry.valid;
            slot_in  = prev_entry.slot;
         end
         CELL_REMOVE: begin
            if (found_out) begin
               valid_in = next_entry.valid;
               slot_in  = next_entry.slot;
            end
         end
         CELL_CLEAR: valid_in = 1'b0;
         CELL_BUMP: begin
            if (sel && (slot_ff.hits != HITS_MAX)) begin
               slot_in.hits = slot_ff.hits + HITS_W'(1);
            end
         end
         CELL_ROTATE: begin
            valid_in = next_entry.valid;
            slot_in  = next_entry.slot;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cover_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         cover_ff <= cover_in;
      end
      slot_ff <= slot_in;
   end

endmodule

>>> design/range_watchpoint_table.sv
// Top level of the range watchpoint table: request decode, cell chain and result register.
//
// Requests arrive on the req_ stream: req_tuser carries the request code (add, remove,
// clear all, fault event, list) and req_tdata the process id, address, length, access
// mask and fault kind. Results leave on the rsp_ stream; rsp_tuser is set when the entry
// fields of the result are meaningful, and rsp_tlast marks the final item of a request.
// Every request gives one result item, except a list, which gives one item per matching
// entry (newest first, at most 16) or a single empty item when nothing matches.
// Add, remove, clear and fault requests pass through the accept cycle, in which every
// cell registers its range compare, and a resolve step that settles priority and updates
// the table once the result register is free. A list rotates the table once through
// cell 0 to count matches and once more to emit them, restoring the original order.
// One request is worked on at a time; req_tready is high only while the block is idle.
// The result register lets a new request be accepted while an item still waits; when the
// receiver stalls, the block holds any step that gives an item (a list holds its emit
// rotation) until the pending item is taken. Synchronous reset empties the table and
// drops any pending item; no clearing pass is needed since only the valid bits are reset.
module range_watchpoint_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_type
   input  logic [rwt_pkg::OP_W-1:0]         req_tuser,
   // proc_id, address, length, access_mask, fault_kind, zero fill
   input  logic [rwt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_valid
   output logic                             rsp_tuser,
   // status, hit, out_proc_id, out_address, out_length, out_access, out_hits,
   // match_total, zero fill
   output logic [rwt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import rwt_pkg::*;

   localparam int STEP_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_ACT, S_COUNT, S_EMIT} state_type;

   typedef struct packed {
      req_op_type   op;
      req_data_type data;
   } req_latch_type;

   state_type          state_ff, state_in;
   req_latch_type      req_ff, req_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [EMIT_W-1:0]  emitted_ff, emitted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   req_data_type       req_live;
   cell_ctrl_type      ctrl;
   entry_type          entry_vec [TABLE_DEPTH];
   entry_type          new_entry, last_next;
   logic [TABLE_DEPTH-1:0] found_vec, sel_vec, valid_vec;
   logic [$bits(slot_type)-1:0] sel_bits;
   slot_type           sel_slot;
   logic               out_free, any_cover, table_full, fault_hit;
   logic               list_match, emit_now, need_out, advance, last_step;
   logic [EMIT_W-1:0]  emit_limit;

   assign req_live   = req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Entry written into cell 0 by an add.
   assign new_entry.valid       = 1'b1;
   assign new_entry.slot.proc   = req_ff.data.proc;
   assign new_entry.slot.start  = req_ff.data.addr;
   assign new_entry.slot.len    = req_ff.data.len;
   assign new_entry.slot.access = req_ff.data.mask;
   assign new_entry.slot.hits   = '0;

   // The far end of the chain wraps to cell 0 while rotating and is empty otherwise,
   // so a remove closes the gap and frees the oldest cell.
   assign last_next.valid = (ctrl.cmd == CELL_ROTATE) & entry_vec[0].valid;
   assign last_next.slot  = entry_vec[0].slot;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      fin;
      if (i == 0) begin : g_head
         assign prev_e = new_entry;
         assign fin    = 1'b0;
      end else begin : g_body
         assign prev_e = entry_vec[i-1];
         assign fin    = found_vec[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_e = last_next;
      end else begin : g_link
         assign next_e = entry_vec[i+1];
      end

      rwt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .found_in   (fin),
         .found_out  (found_vec[i]),
         .sel        (sel_vec[i]),
         .entry      (entry_vec[i])
      );

      assign valid_vec[i] = entry_vec[i].valid;
   end

   // The selected cell is one-hot, so an AND-OR picks its contents.
   always_comb begin
      sel_bits = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         sel_bits = sel_bits | ({$bits(slot_type){sel_vec[i]}} & entry_vec[i].slot);
      end
   end
   assign sel_slot = slot_type'(sel_bits);

   assign any_cover  = found_vec[TABLE_DEPTH-1];
   assign table_full = entry_vec[TABLE_DEPTH-1].valid;
   assign fault_hit  = any_cover && ((sel_slot.access & kind_mask(req_ff.data.kind)) != '0);

   // List scan: the entry under inspection is always the one in cell 0.
   assign list_match = entry_vec[0].valid &&
                       ((req_ff.data.proc == '0) || (entry_vec[0].slot.proc == req_ff.data.proc));
   assign emit_now   = list_match && (emitted_ff < EMIT_W'(MAX_RESULTS));
   assign emit_limit = (total_ff > TOTAL_W'(MAX_RESULTS)) ? EMIT_W'(MAX_RESULTS)
                                                          : EMIT_W'(total_ff);
   assign last_step  = (step_ff == STEP_W'(TABLE_DEPTH - 1));
   assign need_out   = emit_now || (last_step && (total_ff == '0));
   assign advance    = ~need_out | out_free;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl.cmd     = CELL_HOLD;
      ctrl.pid     = req_live.proc;
      ctrl.addr    = req_live.addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in.op   = req_op_type'(req_tuser);
               req_in.data = req_live;
               ctrl.cmd    = CELL_PROBE;
               state_in    = S_ACT;
            end
         end

         S_ACT: begin
            if (req_ff.op == REQ_LIST) begin
               step_in  = '0;
               total_in = '0;
               state_in = S_COUNT;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               unique case (req_ff.op)
                  REQ_ADD: begin
                     // An overlap of the same process wins over a full table.
                     if (any_cover) begin
                        rsp_data_in.status = ST_EXISTS;
                     end else if (table_full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        ctrl.cmd           = CELL_ADD;
                        rsp_data_in.status = ST_OK;
                     end
                  end
                  REQ_REMOVE: begin
                     if (any_cover) begin
                        ctrl.cmd           = CELL_REMOVE;
                        rsp_data_in.status = ST_OK;
                     end else begin
                        rsp_data_in.status = ST_NOT_FOUND;
                     end
                  end
                  REQ_CLEAR: begin
                     ctrl.cmd           = CELL_CLEAR;
                     rsp_data_in.status = ST_OK;
                  end
                  REQ_FAULT: begin
                     // Only the newest covering entry decides whether to trap.
                     if (req_ff.data.kind == KIND_BAD) begin
                        rsp_data_in.status = ST_BAD;
                     end else if (fault_hit) begin
                        ctrl.cmd           = CELL_BUMP;
                        rsp_data_in.status = ST_OK;
                        rsp_data_in.hit    = 1'b1;
                        rsp_data_in.proc   = sel_slot.proc;
                        rsp_data_in.addr   = sel_slot.start;
                        rsp_data_in.len    = sel_slot.len;
                        rsp_data_in.access = sel_slot.access;
                        rsp_data_in.hits   = (sel_slot.hits == HITS_MAX) ? HITS_MAX
                                             : sel_slot.hits + HITS_W'(1);
                        rsp_user_in        = 1'b1;
                     end else begin
                        rsp_data_in.status = ST_OK;
                     end
                  end
                  default: rsp_data_in.status = ST_BAD;
               endcase
            end
         end

         S_COUNT: begin
            ctrl.cmd = CELL_ROTATE;
            step_in  = step_ff + STEP_W'(1);
            if (list_match) begin
               total_in = total_ff + TOTAL_W'(1);
            end
            if (last_step) begin
               step_in    = '0;
               emitted_in = '0;
               state_in   = S_EMIT;
            end
         end

         S_EMIT: begin
            if (advance) begin
               ctrl.cmd = CELL_ROTATE;
               step_in  = step_ff + STEP_W'(1);
               if (emit_now) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.status = ST_OK;
                  rsp_data_in.proc   = entry_vec[0].slot.proc;
                  rsp_data_in.addr   = entry_vec[0].slot.start;
                  rsp_data_in.len    = entry_vec[0].slot.len;
                  rsp_data_in.access = entry_vec[0].slot.access;
                  rsp_data_in.hits   = entry_vec[0].slot.hits;
                  rsp_data_in.total  = total_ff;
                  rsp_user_in        = 1'b1;
                  rsp_last_in        = (emitted_ff + EMIT_W'(1)) == emit_limit;
                  emitted_in         = emitted_ff + EMIT_W'(1);
               end else if (need_out) begin
                  // Nothing matched: one empty item closes the request.
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.status = ST_OK;
                  rsp_user_in        = 1'b0;
                  rsp_last_in        = 1'b1;
               end
               if (last_step) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         total_ff     <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         total_ff     <= total_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // At most one cell may claim priority for a probe.
   assert property (@(posedge clock) disable iff (reset) $onehot0(sel_vec))
      else $error("more than one cell selected");

   // Between requests the valid entries form one run starting at the newest cell.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
      else $error("valid entries are not contiguous");

   // An accepted request always reaches the resolve state in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_ACT))
      else $error("accepted request not resolved");

   // A list never emits more items than the limit or the match count allows.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (emitted_ff <= emit_limit))
      else $error("list emitted too many items");

   // The match count cannot exceed the table size.
   assert property (@(posedge clock) disable iff (reset)
      (total_ff <= TOTAL_W'(TABLE_DEPTH)))
      else $error("match count overflow");
`endif

endmodule
